FILE: hdl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the masked signature scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int LEN_BITS        = 5;
	localparam int HIT_OFFSET_BITS = 32;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 64;
	localparam int PATTERN_BYTES   = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PATTERN_LOW    = 3'd0,
		CFG_PATTERN_HIGH   = 3'd1,
		CFG_CARE_MASK      = 3'd2,
		CFG_HOLE_MASK      = 3'd3,
		CFG_PATTERN_LENGTH = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic                       found;
		logic [HIT_OFFSET_BITS-1:0] hit_offset;
	} result_t;

	typedef struct packed {
		logic advance;
		logic clear;
	} cell_ctrl_t;

endpackage

FILE: hdl/mss_cell.sv
// ----------------------------------------------------------------------------
// mss_cell
// One window byte: shifts toward the older end and compares its incoming
// byte with the aligned pattern byte.
// ----------------------------------------------------------------------------
module mss_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mss_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]         shift_in,
	input  logic [7:0]         pattern_byte,
	input  logic               care,
	output logic [7:0]         shift_out,
	output logic               mismatch
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.advance) begin
			byte_q <= ctrl.clear ? 8'd0 : shift_in;
		end
	end

	assign shift_out = byte_q;
	assign mismatch  = care && (shift_in != pattern_byte);

endmodule

FILE: hdl/masked_signature_scan.sv
// ----------------------------------------------------------------------------
// masked_signature_scan
// Masked byte-pattern search over a byte stream.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock. A row of MAX_PATTERN cells holds the
// window; every cell compares its incoming byte with its aligned pattern
// byte in the transfer cycle, so match, wildcard offset and the result are
// settled in that cycle; the result shows in the cycle after the transfer.
// The item channel stalls only while a result waits in the output register
// and result_stall is high. At most one result per stream: a hit with the
// offset of the first wildcard, or not found on the last byte. All scan
// state clears on the last byte; configuration keeps its values.
// ----------------------------------------------------------------------------
module masked_signature_scan #(
	parameter int MAX_PATTERN = mss_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = mss_pkg::OFFSET_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  mss_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output mss_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [mss_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int LB = mss_pkg::LEN_BITS;

	logic [63:0]        pattern_low_q;
	logic [63:0]        pattern_high_q;
	logic [15:0]        care_mask_q;
	logic [15:0]        hole_mask_q;
	logic [LB-1:0]      pattern_length_q;

	logic [OFFSET_BITS-1:0] count_q;
	logic                   hit_seen_q;
	logic                   result_valid_q;
	mss_pkg::result_t       result_q;

	logic [LB-1:0]      len_eff;
	logic [7:0]         pat_byte [mss_pkg::PATTERN_BYTES];
	logic [7:0]         al_pat   [MAX_PATTERN];
	logic               al_care  [MAX_PATTERN];
	logic [7:0]         win      [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] mism;
	logic               has_hole;
	logic [LB-1:0]      hole_dist;
	logic               accept;
	logic               pos_ok;
	logic               hit;
	logic               emit;
	logic [OFFSET_BITS-1:0] off;
	mss_pkg::cell_ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			hole_mask_q      <= '0;
			pattern_length_q <= LB'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mss_pkg::CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				mss_pkg::CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				mss_pkg::CFG_CARE_MASK:      care_mask_q      <= cfg_data[15:0];
				mss_pkg::CFG_HOLE_MASK:      hole_mask_q      <= cfg_data[15:0];
				mss_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LB-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective length and pattern alignment to the newest end of the row
	always_comb begin
		logic [LB:0] kk;
		if (pattern_length_q == '0) begin
			len_eff = LB'(1);
		end else if (32'(pattern_length_q) > MAX_PATTERN) begin
			len_eff = LB'(MAX_PATTERN);
		end else begin
			len_eff = pattern_length_q;
		end
		for (int b = 0; b < 8; b++) begin
			pat_byte[b]     = pattern_low_q[8*b +: 8];
			pat_byte[b + 8] = pattern_high_q[8*b +: 8];
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			kk = (LB+1)'(j) + (LB+1)'(len_eff) - (LB+1)'(MAX_PATTERN);
			if ((LB+1)'(j) + (LB+1)'(len_eff) >= (LB+1)'(MAX_PATTERN)) begin
				al_pat[j]  = pat_byte[kk[3:0]];
				al_care[j] = care_mask_q[kk[3:0]];
			end else begin
				al_pat[j]  = 8'd0;
				al_care[j] = 1'b0;
			end
		end
	end

	// lowest wildcard below the length, as distance back from the newest byte
	always_comb begin
		has_hole  = 1'b0;
		hole_dist = '0;
		for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
			if (hole_mask_q[k] && (LB'(k) < len_eff)) begin
				has_hole  = 1'b1;
				hole_dist = len_eff - LB'(1) - LB'(k);
			end
		end
	end

	assign item_stall = result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign ctrl.advance = accept;
	assign ctrl.clear   = item.last_byte;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [7:0] sin;
		if (j == MAX_PATTERN - 1) begin : g_head
			assign sin = item.data_byte;
		end else begin : g_body
			assign sin = win[j + 1];
		end
		mss_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.shift_in     (sin),
			.pattern_byte (al_pat[j]),
			.care         (al_care[j]),
			.shift_out    (win[j]),
			.mismatch     (mism[j])
		);
	end

	assign pos_ok = count_q >= OFFSET_BITS'(len_eff - LB'(1));
	assign hit    = !hit_seen_q && pos_ok && (mism == '0) && has_hole;
	assign emit   = hit || (item.last_byte && !hit_seen_q);
	assign off    = count_q - OFFSET_BITS'(hole_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			hit_seen_q <= 1'b0;
		end else if (accept) begin
			if (item.last_byte) begin
				count_q    <= '0;
				hit_seen_q <= 1'b0;
			end else begin
				if (count_q != '1) begin
					count_q <= count_q + OFFSET_BITS'(1);
				end
				hit_seen_q <= hit_seen_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			result_q.found      <= hit;
			result_q.hit_offset <= hit ? mss_pkg::HIT_OFFSET_BITS'(off)
			                           : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_last_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_byte) |=> (count_q == '0 && !hit_seen_q))
		else $error("scan state not cleared after last byte");

	a_hit_sets_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit && !item.last_byte) |=> hit_seen_q)
		else $error("hit not recorded");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit_seen_q) |=> !(result_valid && result.found))
		else $error("second hit reported in one stream");

	a_found_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && !hit) |=> (result.hit_offset == '0))
		else $error("not found result carries an offset");

endmodule
